@@ sv/wvd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wvd_pkg;

   localparam int MOLECULES   = 4096;
   localparam int IDX_W       = $clog2(MOLECULES);
   localparam logic [15:0] DT_RESET = 16'd2000;

   localparam int DIV_STAGES  = 16;
   localparam int DIV_STEPS   = 32 / DIV_STAGES;
   localparam int SQRT_STAGES = 16;
   localparam int SQRT_STEPS  = 32 / SQRT_STAGES;

   // front stages, velocity divide, saturate/square/sum, root
   localparam int FRONT_DEPTH = 5;
   localparam int PIPE_DEPTH  = FRONT_DEPTH + DIV_STAGES + 3 + SQRT_STAGES;

   typedef struct packed {
      logic [31:0] rem;
      logic        q;
   } div_step_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
   } sqrt_step_type;

   typedef struct packed {
      logic       first;
      logic [2:0] neg;
      logic [2:0] big;
   } vel_sb_type;

   typedef struct packed {
      logic       zero;
      logic [2:0] neg;
   } dip_sb_type;

   function automatic div_step_type div_step(input logic [31:0] rem, input logic nb,
                                             input logic [31:0] den);
      div_step_type r;
      logic [32:0]  acc;
      logic [32:0]  diff;
      acc  = {rem, nb};
      diff = acc - {1'b0, den};
      if (acc >= {1'b0, den}) begin
         r.rem = diff[31:0];
         r.q   = 1'b1;
      end else begin
         r.rem = acc[31:0];
         r.q   = 1'b0;
      end
      return r;
   endfunction

   function automatic sqrt_step_type sqrt_step(input logic [33:0] rem,
                                               input logic [31:0] root,
                                               input logic [1:0]  pair);
      sqrt_step_type r;
      logic [35:0]   acc;
      logic [35:0]   trial;
      logic [35:0]   diff;
      acc   = {rem, pair};
      trial = {2'b00, root, 2'b01};
      diff  = acc - trial;
      if (acc >= trial) begin
         r.rem  = diff[33:0];
         r.root = {root[30:0], 1'b1};
      end else begin
         r.rem  = acc[33:0];
         r.root = {root[30:0], 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/wvd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface wvd_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] molecule_index;
   logic        first_step;
   logic [31:0] oxygen_x;
   logic [31:0] oxygen_y;
   logic [31:0] oxygen_z;
   logic [31:0] hydrogen1_x;
   logic [31:0] hydrogen1_y;
   logic [31:0] hydrogen1_z;
   logic [31:0] hydrogen2_x;
   logic [31:0] hydrogen2_y;
   logic [31:0] hydrogen2_z;

   modport source (output valid, molecule_index, first_step, oxygen_x, oxygen_y, oxygen_z,
                   hydrogen1_x, hydrogen1_y, hydrogen1_z, hydrogen2_x, hydrogen2_y,
                   hydrogen2_z, input ready);
   modport sink (input valid, molecule_index, first_step, oxygen_x, oxygen_y, oxygen_z,
                 hydrogen1_x, hydrogen1_y, hydrogen1_z, hydrogen2_x, hydrogen2_y,
                 hydrogen2_z, output ready);
endinterface

interface wvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] speed;
   logic [31:0] velocity_x;
   logic [31:0] velocity_y;
   logic [31:0] velocity_z;
   logic [31:0] dipole_x;
   logic [31:0] dipole_y;
   logic [31:0] dipole_z;
   logic        zero_dipole;

   modport source (output valid, speed, velocity_x, velocity_y, velocity_z, dipole_x,
                   dipole_y, dipole_z, zero_dipole, input ready);
   modport sink (input valid, speed, velocity_x, velocity_y, velocity_z, dipole_x,
                 dipole_y, dipole_z, zero_dipole, output ready);
endinterface

interface wvd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] time_step_fs;

   modport source (output valid, time_step_fs, input ready);
   modport sink (input valid, time_step_fs, output ready);
endinterface
`default_nettype wire

@@ sv/water_velocity_and_dipole_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Water velocity and dipole pipeline. One request per cycle is taken while the pipeline
// advances; responses appear in request order. While a finished response waits, the
// pipeline keeps moving as long as its last stage holds no request, else it stalls. A
// request passes the five front stages, the 16-stage velocity divider, saturate, square
// and sum registers, the 16-stage square root for the speed and the output register;
// the dipole path (root then divide) is equal in length. The previous oxygen position
// of each of the 4096 molecules lives in a single-port store that is read and rewritten
// at the edge that accepts the request, so requests for the same molecule may follow in
// consecutive cycles. Entries come up undefined: the first request of each molecule must
// carry first_step. The user must write time_step_fs through the csr channel only while
// idle; the block itself does not enforce this. 0 acts as 1.
module water_velocity_and_dipole_top import wvd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wvd_req_if.sink   req_ch,
   wvd_rsp_if.source rsp_ch,
   wvd_csr_if.sink   csr_ch
);

   localparam int VSB_LEN = DIV_STAGES;
   localparam int VEL_LEN = 2 + SQRT_STAGES;
   localparam int DM_LEN  = 2 + SQRT_STAGES;
   localparam int DSB_LEN = PIPE_DEPTH - FRONT_DEPTH;

   logic [15:0] dt_ff;
   logic [15:0] dt0;
   logic        pipe_adv;
   logic        out_free;
   logic        accept;
   logic        vld_ff [PIPE_DEPTH];
   logic        rsp_valid_ff;

   // csr
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= DT_RESET;
      end else if (csr_ch.valid) begin
         dt_ff <= csr_ch.time_step_fs;
      end
   end
   assign dt0 = (dt_ff == 16'd0) ? 16'd1 : dt_ff;

   // flow control
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign pipe_adv     = !vld_ff[PIPE_DEPTH-1] || out_free;
   assign req_ch.ready = pipe_adv;
   assign accept       = req_ch.valid && pipe_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pipe_adv) begin
            vld_ff[0] <= req_ch.valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (out_free) begin
            rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
         end
      end
   end

   // previous position store
   logic [2:0][31:0] cur_ox;
   logic [95:0]      prev_raw;
   logic [2:0][31:0] prev;

   assign cur_ox = {req_ch.oxygen_z, req_ch.oxygen_y, req_ch.oxygen_x};

   wvd_ram #(
      .WIDTH (96),
      .DEPTH (MOLECULES)
   ) u_store (
      .clock (clock),
      .en    (accept),
      .we    (accept),
      .addr  (req_ch.molecule_index[IDX_W-1:0]),
      .wdata (cur_ox),
      .rdata (prev_raw)
   );
   assign prev = prev_raw;

   // stage 1
   logic             s1_first_ff;
   logic [2:0][31:0] s1_ox_ff;
   logic [2:0][31:0] s1_h1_ff;
   logic [2:0][31:0] s1_h2_ff;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s1_first_ff <= req_ch.first_step;
         s1_ox_ff    <= cur_ox;
         s1_h1_ff    <= {req_ch.hydrogen1_z, req_ch.hydrogen1_y, req_ch.hydrogen1_x};
         s1_h2_ff    <= {req_ch.hydrogen2_z, req_ch.hydrogen2_y, req_ch.hydrogen2_x};
      end
   end

   // stage 2: displacement and doubled dipole
   logic             s2_first_ff;
   logic [2:0]       s2_vneg_ff,  s2_vneg_in;
   logic [2:0][32:0] s2_vmag_ff,  s2_vmag_in;
   logic [2:0]       s2_dneg_ff,  s2_dneg_in;
   logic [2:0][33:0] s2_dmag_ff,  s2_dmag_in;

   always_comb begin
      logic [32:0] d;
      logic [33:0] dd;
      for (int i = 0; i < 3; i++) begin
         d  = {s1_ox_ff[i][31], s1_ox_ff[i]} - {prev[i][31], prev[i]};
         dd = {{2{s1_h1_ff[i][31]}}, s1_h1_ff[i]} + {{2{s1_h2_ff[i][31]}}, s1_h2_ff[i]}
              - {s1_ox_ff[i][31], s1_ox_ff[i], 1'b0};
         s2_vneg_in[i] = d[32];
         s2_vmag_in[i] = d[32] ? (33'd0 - d) : d;
         s2_dneg_in[i] = dd[33];
         s2_dmag_in[i] = dd[33] ? (34'd0 - dd) : dd;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s2_first_ff <= s1_first_ff;
         s2_vneg_ff  <= s2_vneg_in;
         s2_vmag_ff  <= s2_vmag_in;
         s2_dneg_ff  <= s2_dneg_in;
         s2_dmag_ff  <= s2_dmag_in;
      end
   end

   // stage 3: rounded numerators, coarse normalize
   vel_sb_type       s3_vsb_ff,  s3_vsb_in;
   logic [2:0][40:0] s3_num_ff,  s3_num_in;
   dip_sb_type       s3_dsb_ff,  s3_dsb_in;
   logic [2:0][30:0] s3_m_ff,    s3_m_in;

   always_comb begin
      logic [33:0] o;
      logic [33:0] sh;
      logic [30:0] o2;
      s3_vsb_in.first = s2_first_ff;
      s3_vsb_in.neg   = s2_vneg_ff;
      for (int i = 0; i < 3; i++) begin
         s3_num_in[i]     = {s2_vmag_ff[i], 8'd0} + {26'd0, dt0[15:1]};
         s3_vsb_in.big[i] = {7'd0, s3_num_in[i][40:32]} >= dt0;
      end
      o = s2_dmag_ff[0] | s2_dmag_ff[1] | s2_dmag_ff[2];
      s3_dsb_in.zero = (o == 34'd0);
      s3_dsb_in.neg  = s2_dneg_ff;
      for (int i = 0; i < 3; i++) begin
         if (o[33]) begin
            sh = s2_dmag_ff[i] >> 3;
         end else if (o[32]) begin
            sh = s2_dmag_ff[i] >> 2;
         end else if (o[31]) begin
            sh = s2_dmag_ff[i] >> 1;
         end else begin
            sh = s2_dmag_ff[i];
         end
         s3_m_in[i] = sh[30:0];
      end
      o2 = s3_m_in[0] | s3_m_in[1] | s3_m_in[2];
      if (o2[30:15] == 16'd0) begin
         for (int i = 0; i < 3; i++) begin
            s3_m_in[i] = s3_m_in[i] << 16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s3_vsb_ff <= s3_vsb_in;
         s3_num_ff <= s3_num_in;
         s3_dsb_ff <= s3_dsb_in;
         s3_m_ff   <= s3_m_in;
      end
   end

   // stages 4 and 5: fine normalize
   vel_sb_type       s4_vsb_ff, s5_vsb_ff;
   logic [2:0][40:0] s4_num_ff, s5_num_ff;
   dip_sb_type       s4_dsb_ff, s5_dsb_ff;
   logic [2:0][30:0] s4_m_ff,   s4_m_in;
   logic [2:0][30:0] s5_m_ff,   s5_m_in;

   always_comb begin
      logic [30:0] o;
      s4_m_in = s3_m_ff;
      o = s4_m_in[0] | s4_m_in[1] | s4_m_in[2];
      if (o[30:23] == 8'd0) begin
         for (int i = 0; i < 3; i++) begin
            s4_m_in[i] = s4_m_in[i] << 8;
         end
      end
      o = s4_m_in[0] | s4_m_in[1] | s4_m_in[2];
      if (o[30:27] == 4'd0) begin
         for (int i = 0; i < 3; i++) begin
            s4_m_in[i] = s4_m_in[i] << 4;
         end
      end
   end

   always_comb begin
      logic [30:0] o;
      s5_m_in = s4_m_ff;
      o = s5_m_in[0] | s5_m_in[1] | s5_m_in[2];
      if (o[30:29] == 2'd0) begin
         for (int i = 0; i < 3; i++) begin
            s5_m_in[i] = s5_m_in[i] << 2;
         end
      end
      o = s5_m_in[0] | s5_m_in[1] | s5_m_in[2];
      if (!o[30]) begin
         for (int i = 0; i < 3; i++) begin
            s5_m_in[i] = s5_m_in[i] << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s4_vsb_ff <= s3_vsb_ff;
         s4_num_ff <= s3_num_ff;
         s4_dsb_ff <= s3_dsb_ff;
         s4_m_ff   <= s4_m_in;
         s5_vsb_ff <= s4_vsb_ff;
         s5_num_ff <= s4_num_ff;
         s5_dsb_ff <= s4_dsb_ff;
         s5_m_ff   <= s5_m_in;
      end
   end

   // velocity: divide, saturate, square, sum, root
   logic [2:0][31:0] vq;
   vel_sb_type       vsb_ff [VSB_LEN];
   logic [2:0][31:0] vsat_ff, vsat_in;
   logic [2:0][31:0] vabs_ff, vabs_in;
   logic [2:0][31:0] vel_ff [VEL_LEN];
   logic [2:0][63:0] vsq_ff;
   logic [63:0]      vsum_ff;
   logic [31:0]      vroot;
   logic [33:0]      vrem;

   for (genvar i = 0; i < 3; i++) begin : g_vdiv
      wvd_div u_div (
         .clock (clock),
         .en    (pipe_adv),
         .num_i ({23'd0, s5_num_ff[i]}),
         .den_i ({16'd0, dt0}),
         .quo_o (vq[i])
      );
   end

   always_comb begin
      vel_sb_type sb;
      sb = vsb_ff[VSB_LEN-1];
      for (int i = 0; i < 3; i++) begin
         if (sb.first) begin
            vsat_in[i] = 32'd0;
            vabs_in[i] = 32'd0;
         end else if (sb.neg[i]) begin
            if (sb.big[i] || vq[i] > 32'h8000_0000) begin
               vsat_in[i] = 32'h8000_0000;
               vabs_in[i] = 32'h8000_0000;
            end else begin
               vsat_in[i] = 32'd0 - vq[i];
               vabs_in[i] = vq[i];
            end
         end else if (sb.big[i] || vq[i][31]) begin
            vsat_in[i] = 32'h7FFF_FFFF;
            vabs_in[i] = 32'h7FFF_FFFF;
         end else begin
            vsat_in[i] = vq[i];
            vabs_in[i] = vq[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         vsb_ff[0] <= s5_vsb_ff;
         for (int k = 1; k < VSB_LEN; k++) begin
            vsb_ff[k] <= vsb_ff[k-1];
         end
         vsat_ff   <= vsat_in;
         vabs_ff   <= vabs_in;
         vel_ff[0] <= vsat_ff;
         for (int k = 1; k < VEL_LEN; k++) begin
            vel_ff[k] <= vel_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            vsq_ff[i] <= vabs_ff[i] * vabs_ff[i];
         end
         vsum_ff <= vsq_ff[0] + vsq_ff[1] + vsq_ff[2];
      end
   end

   wvd_sqrt u_vsqrt (
      .clock  (clock),
      .en     (pipe_adv),
      .rad_i  (vsum_ff),
      .root_o (vroot),
      .rem_o  (vrem)
   );

   // dipole: square, sum, root, divide
   logic [2:0][30:0] dm_ff [DM_LEN];
   dip_sb_type       dsb_ff [DSB_LEN];
   logic [2:0][61:0] dsq_ff;
   logic [63:0]      dsum_ff;
   logic [31:0]      dlen;
   logic [2:0][63:0] dnum_ff;
   logic [31:0]      dden_ff;
   logic [2:0][31:0] dq;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         dm_ff[0] <= s5_m_ff;
         for (int k = 1; k < DM_LEN; k++) begin
            dm_ff[k] <= dm_ff[k-1];
         end
         dsb_ff[0] <= s5_dsb_ff;
         for (int k = 1; k < DSB_LEN; k++) begin
            dsb_ff[k] <= dsb_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            dsq_ff[i]  <= s5_m_ff[i] * s5_m_ff[i];
            dnum_ff[i] <= {3'd0, dm_ff[DM_LEN-1][i], 30'd0} + {33'd0, dlen[31:1]};
         end
         dsum_ff <= {2'd0, dsq_ff[0]} + {2'd0, dsq_ff[1]} + {2'd0, dsq_ff[2]};
         dden_ff <= dlen;
      end
   end

   wvd_sqrt u_dsqrt (
      .clock  (clock),
      .en     (pipe_adv),
      .rad_i  (dsum_ff),
      .root_o (dlen),
      .rem_o  ()
   );

   for (genvar i = 0; i < 3; i++) begin : g_ddiv
      wvd_div u_div (
         .clock (clock),
         .en    (pipe_adv),
         .num_i (dnum_ff[i]),
         .den_i (dden_ff),
         .quo_o (dq[i])
      );
   end

   // output register
   logic [30:0]      speed_ff, speed_in;
   logic [2:0][31:0] vout_ff;
   logic [2:0][31:0] dout_ff, dout_in;
   logic             zero_ff;

   always_comb begin
      logic [32:0] rr;
      dip_sb_type  sb;
      rr = {1'b0, vroot} + {32'd0, (vrem > {2'b00, vroot})};
      speed_in = (rr > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : rr[30:0];
      sb = dsb_ff[DSB_LEN-1];
      for (int i = 0; i < 3; i++) begin
         if (sb.zero) begin
            dout_in[i] = 32'd0;
         end else if (sb.neg[i]) begin
            dout_in[i] = 32'd0 - dq[i];
         end else begin
            dout_in[i] = dq[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         speed_ff <= speed_in;
         vout_ff  <= vel_ff[VEL_LEN-1];
         dout_ff  <= dout_in;
         zero_ff  <= dsb_ff[DSB_LEN-1].zero;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.speed       = speed_ff;
   assign rsp_ch.velocity_x  = vout_ff[0];
   assign rsp_ch.velocity_y  = vout_ff[1];
   assign rsp_ch.velocity_z  = vout_ff[2];
   assign rsp_ch.dipole_x    = dout_ff[0];
   assign rsp_ch.dipole_y    = dout_ff[1];
   assign rsp_ch.dipole_z    = dout_ff[2];
   assign rsp_ch.zero_dipole = zero_ff;

endmodule
`default_nettype wire

@@ sv/wvd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wvd_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a request sees the value left by the previous one
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff <= mem[addr];
         if (we) begin
            mem[addr] <= wdata;
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ sv/wvd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wvd_div import wvd_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num_i,
   input  logic [31:0] den_i,
   output logic [31:0] quo_o
);

   // restoring divide, num_i[63:32] < den_i expected
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] low;
      logic [31:0] den;
      logic [31:0] quo;
   } div_stage_type;

   div_stage_type stage_ff [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];

   always_comb begin
      div_stage_type cur;
      div_step_type  st;
      cur.rem = num_i[63:32];
      cur.low = num_i[31:0];
      cur.den = den_i;
      cur.quo = '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
         for (int j = 0; j < DIV_STEPS; j++) begin
            st      = div_step(cur.rem, cur.low[31], cur.den);
            cur.rem = st.rem;
            cur.quo = {cur.quo[30:0], st.q};
            cur.low = {cur.low[30:0], 1'b0};
         end
         stage_in[k] = cur;
         cur         = stage_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign quo_o = stage_ff[DIV_STAGES-1].quo;

endmodule
`default_nettype wire

@@ sv/wvd_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wvd_sqrt import wvd_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad_i,
   output logic [31:0] root_o,
   output logic [33:0] rem_o
);

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } sqrt_stage_type;

   sqrt_stage_type stage_ff [SQRT_STAGES];
   sqrt_stage_type stage_in [SQRT_STAGES];

   always_comb begin
      sqrt_stage_type cur;
      sqrt_step_type  st;
      cur.rem  = '0;
      cur.root = '0;
      cur.rad  = rad_i;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         for (int j = 0; j < SQRT_STEPS; j++) begin
            st       = sqrt_step(cur.rem, cur.root, cur.rad[63:62]);
            cur.rem  = st.rem;
            cur.root = st.root;
            cur.rad  = {cur.rad[61:0], 2'b00};
         end
         stage_in[k] = cur;
         cur         = stage_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign root_o = stage_ff[SQRT_STAGES-1].root;
   assign rem_o  = stage_ff[SQRT_STAGES-1].rem;

endmodule
`default_nettype wire

@@ sv/wvd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wvd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] speed,
   input logic [31:0] velocity_x,
   input logic [31:0] velocity_y,
   input logic [31:0] velocity_z,
   input logic [31:0] dipole_x,
   input logic [31:0] dipole_y,
   input logic [31:0] dipole_z,
   input logic        zero_dipole
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(speed) && $stable(velocity_x)
         && $stable(velocity_y) && $stable(velocity_z) && $stable(dipole_x)
         && $stable(dipole_y) && $stable(dipole_z) && $stable(zero_dipole))
      else $error("response changed while stalled");

   a_zero_dipole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_dipole |-> dipole_x == 32'd0 && dipole_y == 32'd0
         && dipole_z == 32'd0)
      else $error("zero dipole with nonzero components");

   a_unit_dipole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !zero_dipole |-> dipole_x != 32'd0 || dipole_y != 32'd0
         || dipole_z != 32'd0)
      else $error("unit dipole came out zero");

   a_still_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && velocity_x == 32'd0 && velocity_y == 32'd0 && velocity_z == 32'd0
         |-> speed == 31'd0)
      else $error("speed nonzero at rest");

endmodule

bind water_velocity_and_dipole_top wvd_checker u_wvd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .speed       (rsp_ch.speed),
   .velocity_x  (rsp_ch.velocity_x),
   .velocity_y  (rsp_ch.velocity_y),
   .velocity_z  (rsp_ch.velocity_z),
   .dipole_x    (rsp_ch.dipole_x),
   .dipole_y    (rsp_ch.dipole_y),
   .dipole_z    (rsp_ch.dipole_z),
   .zero_dipole (rsp_ch.zero_dipole)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import wvd_pkg::*;

   typedef struct packed {
      logic [30:0] speed;
      logic [31:0] vx, vy, vz, dx, dy, dz;
      logic        zero;
   } motion_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wvd_req_if req_ch();
   wvd_rsp_if rsp_ch();
   wvd_csr_if csr_ch();

   water_velocity_and_dipole_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   logic [15:0] dt_reg;
   logic [31:0] prev_x [MOLECULES];
   logic [31:0] prev_y [MOLECULES];
   logic [31:0] prev_z [MOLECULES];
   bit          seen [MOLECULES];
   motion_type  expected_q[$];
   int          errors = 0;
   int          sent = 0;
   int          received = 0;
   int          zero_dip = 0;
   int          idle_pct = 31;
   int          stall_hold = 0;
   int          quiet = 0;
   bit          ticking = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.molecule_index = '0;
      req_ch.first_step = 1'b0;
      req_ch.oxygen_x = '0; req_ch.oxygen_y = '0; req_ch.oxygen_z = '0;
      req_ch.hydrogen1_x = '0; req_ch.hydrogen1_y = '0; req_ch.hydrogen1_z = '0;
      req_ch.hydrogen2_x = '0; req_ch.hydrogen2_y = '0; req_ch.hydrogen2_z = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.time_step_fs = '0;
   end

   function automatic logic [63:0] root64(input logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint rate_of(input longint cur, input longint prv,
                                      input longint dt);
      longint d, q;
      d = cur - prv;
      q = ((d < 0 ? -d : d) * 256 + dt / 2) / dt;
      if (d < 0) return q > 64'h80000000 ? -64'sh80000000 : -q;
      return q > 64'h7FFFFFFF ? 64'sh7FFFFFFF : q;
   endfunction

   function automatic motion_type predict_motion(input logic [11:0] idx, input logic first,
      input logic signed [31:0] o[3], input logic signed [31:0] h1[3],
      input logic signed [31:0] h2[3]);
      motion_type  m;
      longint      v[3], dd, dt;
      logic [63:0] mag[3], maxm, s, r, len, c;
      logic        neg[3];
      v = '{0, 0, 0};
      dt = (dt_reg == 0) ? 1 : dt_reg;
      m.speed = '0;
      if (!first) begin
         v[0] = rate_of(o[0], $signed(prev_x[idx]), dt);
         v[1] = rate_of(o[1], $signed(prev_y[idx]), dt);
         v[2] = rate_of(o[2], $signed(prev_z[idx]), dt);
         s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
         r = root64(s);
         if (s - r * r > r) r++;
         m.speed = (r > 64'h7FFFFFFF) ? 31'h7FFFFFFF : r[30:0];
      end
      prev_x[idx] = o[0]; prev_y[idx] = o[1]; prev_z[idx] = o[2];
      m.vx = v[0][31:0]; m.vy = v[1][31:0]; m.vz = v[2][31:0];
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
         dd = longint'(h1[i]) + longint'(h2[i]) - 2 * longint'(o[i]);
         neg[i] = dd < 0;
         mag[i] = neg[i] ? -dd : dd;
         if (mag[i] > maxm) maxm = mag[i];
      end
      m.zero = (maxm == 0);
      m.dx = '0; m.dy = '0; m.dz = '0;
      if (!m.zero) begin
         while (maxm >= 64'h80000000) begin
            maxm = maxm >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         end
         while (maxm < 64'h40000000) begin
            maxm = maxm << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
         len = root64(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
         for (int i = 0; i < 3; i++) begin
            c = ((mag[i] << 30) + len / 2) / len;
            if (neg[i]) c = -c;
            if (i == 0) m.dx = c[31:0];
            else if (i == 1) m.dy = c[31:0];
            else m.dz = c[31:0];
         end
      end
      return m;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s at response %0d: got %h want %h", what, received, got, want);
   endtask

   task automatic send_molecule(input logic [11:0] idx, input logic first,
      input logic signed [31:0] o[3], input logic signed [31:0] h1[3],
      input logic signed [31:0] h2[3]);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.molecule_index <= idx;
      req_ch.first_step <= first;
      req_ch.oxygen_x <= o[0]; req_ch.oxygen_y <= o[1]; req_ch.oxygen_z <= o[2];
      req_ch.hydrogen1_x <= h1[0]; req_ch.hydrogen1_y <= h1[1];
      req_ch.hydrogen1_z <= h1[2];
      req_ch.hydrogen2_x <= h2[0]; req_ch.hydrogen2_y <= h2[1];
      req_ch.hydrogen2_z <= h2[2];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(predict_motion(idx, first, o, h1, h2));
      seen[idx] = 1'b1;
      sent++;
   endtask

   // first_step is forced for molecules not yet written
   task automatic send_random(input logic [11:0] idx, input int style);
      logic signed [31:0] o[3], h1[3], h2[3];
      logic first;
      for (int i = 0; i < 3; i++) begin
         case (style)
            0: begin
               o[i] = $urandom; h1[i] = $urandom; h2[i] = $urandom;
            end
            1: begin
               o[i] = $signed($urandom_range(20'hFFFFF)) - 32'sh80000;
               h1[i] = o[i] + $signed($urandom_range(16'hFFFF)) - 32'sh8000;
               h2[i] = o[i] + $signed($urandom_range(16'hFFFF)) - 32'sh8000;
            end
            default: begin
               o[i] = $urandom_range(7) - 4;
               h1[i] = o[i] + $urandom_range(3) - 1;
               h2[i] = 2 * o[i] - h1[i] + (($urandom_range(3) == 0) ? 1 : 0);
            end
         endcase
      end
      first = !seen[idx] || ($urandom_range(9) == 0);
      send_molecule(idx, first, o, h1, h2);
   endtask

   task automatic write_time_step(input logic [15:0] value);
      int spin;
      spin = 0;
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0 && spin < 100000) begin
         @(posedge clock);
         spin++;
      end
      repeat (50) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.time_step_fs <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      dt_reg = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      motion_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            errors++;
            $display("response %0d arrived with nothing expected", received);
         end else begin
            w = expected_q.pop_front();
            if (rsp_ch.speed !== w.speed) report("speed", rsp_ch.speed, w.speed);
            if (rsp_ch.velocity_x !== w.vx) report("velocity_x", rsp_ch.velocity_x, w.vx);
            if (rsp_ch.velocity_y !== w.vy) report("velocity_y", rsp_ch.velocity_y, w.vy);
            if (rsp_ch.velocity_z !== w.vz) report("velocity_z", rsp_ch.velocity_z, w.vz);
            if (rsp_ch.dipole_x !== w.dx) report("dipole_x", rsp_ch.dipole_x, w.dx);
            if (rsp_ch.dipole_y !== w.dy) report("dipole_y", rsp_ch.dipole_y, w.dy);
            if (rsp_ch.dipole_z !== w.dz) report("dipole_z", rsp_ch.dipole_z, w.dz);
            if (rsp_ch.zero_dipole !== w.zero) report("zero_dipole", rsp_ch.zero_dipole, w.zero);
            if (w.zero) zero_dip++;
         end
         received++;
      end
   end

   always @(posedge clock) begin
      if (!ticking || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet <= 0;
      end else if (quiet >= 20000) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic test_extremes;
      logic signed [31:0] o[3], h1[3], h2[3];
      o = '{32'sh7FFFFFFF, -32'sh80000000, 0};
      h1 = '{-32'sh80000000, 32'sh7FFFFFFF, 0};
      h2 = '{-32'sh80000000, 32'sh7FFFFFFF, 1};
      send_molecule(12'd0, 1'b1, o, h1, h2);
      o = '{-32'sh80000000, 32'sh7FFFFFFF, 0};
      send_molecule(12'd0, 1'b0, o, h1, h2);
      o = '{0, 0, 0}; h1 = '{1, -1, 0}; h2 = '{-1, 1, 0};
      send_molecule(12'hFFF, 1'b1, o, h1, h2);
      o = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
      send_molecule(12'hFFF, 1'b0, o, h1, h2);
      o = '{5, 7, -9}; h1 = '{5, 7, -9}; h2 = '{5, 7, -9};
      send_molecule(12'd1, 1'b1, o, h1, h2);
      o = '{6, 7, -9}; h1 = '{6, 7, -9}; h2 = '{6, 7, -9};
      send_molecule(12'd1, 1'b0, o, h1, h2);
      o = '{0, 0, 0}; h1 = '{-1, 0, 0}; h2 = '{0, 0, 0};
      send_molecule(12'd1, 1'b0, o, h1, h2);
      o = '{-32'sh80000000, -32'sh80000000, -32'sh80000000};
      h1 = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
      h2 = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
      send_molecule(12'hFFF, 1'b0, o, h1, h2);
   endtask

   task automatic test_time_steps;
      logic [15:0] steps[5];
      steps = '{16'd1, 16'd0, 16'hFFFF, 16'd7, 16'd2000};
      foreach (steps[k]) begin
         write_time_step(steps[k]);
         repeat (40) send_random(12'($urandom_range(15)), $urandom_range(2));
      end
   endtask

   task automatic test_back_to_back;
      idle_pct = 0;
      for (int n = 0; n < 200; n++) send_random(12'($urandom_range(3)), 1);
      idle_pct = 31;
   endtask

   task automatic test_backpressure;
      stall_hold = 300;
      for (int n = 0; n < 120; n++) begin
         send_random(12'($urandom_range(63)), $urandom_range(2));
      end
   endtask

   task automatic test_random;
      write_time_step(16'($urandom_range(65535)));
      for (int n = 0; n < 400; n++) send_random(12'($urandom), $urandom_range(9) == 0 ? 0 : 1);
      write_time_step(16'($urandom_range(50) + 1));
      for (int n = 0; n < 300; n++) send_random(12'($urandom_range(255)), $urandom_range(2));
   endtask

   initial begin
      int spin;
      dt_reg = DT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      ticking = 1'b1;
      test_extremes();
      test_time_steps();
      test_back_to_back();
      test_backpressure();
      test_random();
      req_ch.valid <= 1'b0;
      spin = 0;
      while (expected_q.size() != 0 && spin < 200000) begin
         @(posedge clock);
         spin++;
      end
      repeat (60) @(posedge clock);
      $display("covered %0d requests, %0d responses, %0d zero-length dipoles,", sent,
               received, zero_dip);
      $display("time steps 0, 1, 7, 2000, 65535 and random, with a long response stall");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
